### sv/abdd_pkg.sv
// Shared widths, reset values, register indexes and item types of the ADC batch stats block.
`default_nettype none
package abdd_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned AVG_W    = 28;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned GAP_W    = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 16'd66;
  localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = 12'd228;
  localparam logic [LEVEL_W-1:0]  RELEASE_RESET   = 12'd68;

  localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_RELEASE   = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [AVG_W-1:0]    average;
    logic [GAP_W-1:0]    gap;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]    interval_sum;
    logic [GAP_W-1:0]    max_interval;
    logic [GAP_W-1:0]    min_interval;
    logic [AVG_W-1:0]    average_q16;
    logic [SAMPLE_W-1:0] max_sample;
    logic [SAMPLE_W-1:0] min_sample;
    logic [COUNT_W-1:0]  dips_in_batch;
    logic [COUNT_W-1:0]  samples_in_batch;
  } stats_t;

endpackage
`default_nettype wire

### sv/adc_batch_stats_dip_detector_top.sv
// Top level of the ADC batch statistics and dip detector.
`default_nettype none
// Takes one ADC item per clock. While a result waits on m_axis, items keep
// flowing until the next last item of a batch reaches the statistics stage;
// the input then stalls with that item and one more held until the result
// drains. An item passes through an input register, a stage that updates
// the moving average and the clipped timestamp interval, and a stage that
// runs dip detection and batch statistics; the last stage registers the
// batch result from the closing item and drives m_axis. The cycle time is set by
// the moving average loop: one 17 x 29 bit signed multiply, a rounding add and
// the accumulate, all feeding back into the average register. Only the last
// item of a batch yields a result. Configuration writes take effect on the
// next clock edge and are meant for idle periods.
module adc_batch_stats_dip_detector_top
  import abdd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,   // sample[11:0], timestamp[59:12], zero
  input  logic                  s_axis_tlast,   // last_of_batch
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [199:0]          m_axis_tdata,   // samples_in_batch, dips_in_batch,
                                                // min_sample, max_sample, average_q16,
                                                // min_interval, max_interval,
                                                // interval_sum, zero
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [WEIGHT_W-1:0] weight_q;
  logic [LEVEL_W-1:0]  thr_q;
  logic [LEVEL_W-1:0]  rel_q;

  logic   s2_v;
  logic   s2_rdy;
  item_t  s2_item;
  stats_t stats;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
      thr_q    <= THRESHOLD_RESET;
      rel_q    <= RELEASE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EMA_WEIGHT:    weight_q <= cfg_data_i[WEIGHT_W-1:0];
        CFG_DIP_THRESHOLD: thr_q    <= cfg_data_i[LEVEL_W-1:0];
        CFG_DIP_RELEASE:   rel_q    <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  abdd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_i     (s_axis_tdata[SAMPLE_W-1:0]),
    .timestamp_i  (s_axis_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
    .last_i       (s_axis_tlast),
    .weight_i     (weight_q),
    .item_valid_o (s2_v),
    .item_ready_i (s2_rdy),
    .item_o       (s2_item)
  );

  abdd_stats u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s2_v),
    .item_ready_o (s2_rdy),
    .item_i       (s2_item),
    .threshold_i  (thr_q),
    .release_i    (rel_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .stats_o      (stats)
  );

  assign m_axis_tdata = {4'b0000, stats};

`ifndef SYNTHESIS
  a_full_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && s2_v && s2_item.last) |-> !s2_rdy)
    else $error("closing item taken over a pending result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s2_v && s2_rdy && s2_item.last))
    else $error("result without a closing item");
`endif

endmodule
`default_nettype wire

### sv/abdd_front.sv
// Input register, moving average update and clipped timestamp interval stage.
`default_nettype none
module abdd_front
  import abdd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [TIME_W-1:0]   timestamp_i,
  input  logic                last_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output item_t               item_o
);

  logic                s1_v_q, s1_v_d;
  logic [SAMPLE_W-1:0] s1_x_q;
  logic [TIME_W-1:0]   s1_ts_q;
  logic                s1_last_q;
  logic                s1_adv;
  logic                in_ready;

  logic [AVG_W-1:0]    avg_q, avg_d;
  logic [TIME_W-1:0]   prior_q, prior_d;
  logic                item_v_q, item_v_d;
  item_t               item_q, item_d;

  logic [AVG_W-1:0]         xq;
  logic signed [AVG_W:0]    diff;
  logic signed [45:0]       prod;
  logic signed [45:0]       rnd;
  logic signed [AVG_W+1:0]  step;
  logic [AVG_W+1:0]         avg_sum;
  logic [TIME_W-1:0]        span;
  logic [GAP_W-1:0]         gap;

  assign s1_adv   = s1_v_q && (!item_v_q || item_ready_i);
  assign in_ready = !s1_v_q || s1_adv;

  // avg + round(w * (x - avg) / 2^16)
  always_comb begin
    xq      = {s1_x_q, {FRAC_W{1'b0}}};
    diff    = $signed({1'b0, xq}) - $signed({1'b0, avg_q});
    prod    = $signed({1'b0, weight_i}) * diff;
    rnd     = prod + 46'sd32768;
    step    = rnd[45:FRAC_W];
    avg_sum = {2'b00, avg_q} + step;
    span    = s1_ts_q - prior_q;
    gap     = (|span[TIME_W-1:GAP_W]) ? {GAP_W{1'b1}} : span[GAP_W-1:0];
  end

  always_comb begin
    s1_v_d   = in_ready ? in_valid_i : s1_v_q;
    avg_d    = s1_adv ? avg_sum[AVG_W-1:0] : avg_q;
    prior_d  = s1_adv ? s1_ts_q : prior_q;
    item_v_d = s1_adv ? 1'b1 : (item_ready_i ? 1'b0 : item_v_q);
    item_d.sample  = s1_x_q;
    item_d.average = avg_sum[AVG_W-1:0];
    item_d.gap     = gap;
    item_d.last    = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      avg_q    <= '0;
      prior_q  <= '0;
      item_v_q <= 1'b0;
    end else begin
      s1_v_q   <= s1_v_d;
      avg_q    <= avg_d;
      prior_q  <= prior_d;
      item_v_q <= item_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      s1_x_q    <= sample_i;
      s1_ts_q   <= timestamp_i;
      s1_last_q <= last_i;
    end
    if (s1_adv) begin
      item_q <= item_d;
    end
  end

  assign in_ready_o   = in_ready;
  assign item_valid_o = item_v_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

### sv/abdd_stats.sv
// Dip detection, batch statistics and result register.
`default_nettype none
module abdd_stats
  import abdd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  item_t              item_i,
  input  logic [LEVEL_W-1:0] threshold_i,
  input  logic [LEVEL_W-1:0] release_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stats_t             stats_o
);

  logic                open_q, open_d;
  logic                act_q, act_d;
  logic [SAMPLE_W-1:0] low_q, low_d;
  logic [SAMPLE_W-1:0] high_q, high_d;
  logic [GAP_W-1:0]    glow_q, glow_d;
  logic [GAP_W-1:0]    ghigh_q, ghigh_d;
  logic [SUM_W-1:0]    gsum_q, gsum_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [COUNT_W-1:0]  dips_q, dips_d;
  logic                out_v_q, out_v_d;
  stats_t              stats_q, stats_d;

  logic                item_ready;
  logic                take;
  logic [AVG_W-1:0]    xq;
  logic [AVG_W-1:0]    dev;
  logic                start;
  logic                rel;
  logic [SAMPLE_W-1:0] low_n, high_n;
  logic [GAP_W-1:0]    glow_n, ghigh_n;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    gsum_n;
  logic [COUNT_W-1:0]  cnt_n, dips_n;

  assign item_ready = !item_i.last || !out_v_q || out_ready_i;
  assign take       = item_valid_i && item_ready;

  always_comb begin
    xq    = {item_i.sample, {FRAC_W{1'b0}}};
    dev   = (xq >= item_i.average) ? (xq - item_i.average) : (item_i.average - xq);
    start = dev >= {threshold_i, {FRAC_W{1'b0}}};
    rel   = dev < {release_i, {FRAC_W{1'b0}}};

    sum_ext = {1'b0, gsum_q} + {{(SUM_W-GAP_W+1){1'b0}}, item_i.gap};
    if (!open_q) begin
      low_n   = item_i.sample;
      high_n  = item_i.sample;
      glow_n  = glow_q;
      ghigh_n = ghigh_q;
      gsum_n  = gsum_q;
    end else begin
      low_n   = (item_i.sample < low_q) ? item_i.sample : low_q;
      high_n  = (item_i.sample > high_q) ? item_i.sample : high_q;
      glow_n  = (item_i.gap < glow_q) ? item_i.gap : glow_q;
      ghigh_n = (item_i.gap > ghigh_q) ? item_i.gap : ghigh_q;
      gsum_n  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end

    cnt_n  = (cnt_q != {COUNT_W{1'b1}}) ? cnt_q + 1'b1 : cnt_q;
    dips_n = (start && !act_q && dips_q != {COUNT_W{1'b1}}) ? dips_q + 1'b1 : dips_q;
  end

  always_comb begin
    open_d  = open_q;
    act_d   = act_q;
    low_d   = low_q;
    high_d  = high_q;
    glow_d  = glow_q;
    ghigh_d = ghigh_q;
    gsum_d  = gsum_q;
    cnt_d   = cnt_q;
    dips_d  = dips_q;
    out_v_d = out_ready_i ? 1'b0 : out_v_q;

    stats_d.samples_in_batch = cnt_n;
    stats_d.dips_in_batch    = dips_n;
    stats_d.min_sample       = low_n;
    stats_d.max_sample       = high_n;
    stats_d.average_q16      = item_i.average;
    stats_d.min_interval     = glow_n;
    stats_d.max_interval     = ghigh_n;
    stats_d.interval_sum     = gsum_n;

    if (take) begin
      if (start) begin
        act_d = 1'b1;
      end else if (act_q && rel) begin
        act_d = 1'b0;
      end
      if (item_i.last) begin
        out_v_d = 1'b1;
        open_d  = 1'b0;
        low_d   = '0;
        high_d  = '0;
        glow_d  = {GAP_W{1'b1}};
        ghigh_d = '0;
        gsum_d  = '0;
        cnt_d   = '0;
        dips_d  = '0;
      end else begin
        open_d  = 1'b1;
        low_d   = low_n;
        high_d  = high_n;
        glow_d  = glow_n;
        ghigh_d = ghigh_n;
        gsum_d  = gsum_n;
        cnt_d   = cnt_n;
        dips_d  = dips_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      act_q   <= 1'b0;
      low_q   <= '0;
      high_q  <= '0;
      glow_q  <= {GAP_W{1'b1}};
      ghigh_q <= '0;
      gsum_q  <= '0;
      cnt_q   <= '0;
      dips_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      open_q  <= open_d;
      act_q   <= act_d;
      low_q   <= low_d;
      high_q  <= high_d;
      glow_q  <= glow_d;
      ghigh_q <= ghigh_d;
      gsum_q  <= gsum_d;
      cnt_q   <= cnt_d;
      dips_q  <= dips_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      stats_q <= stats_d;
    end
  end

  assign item_ready_o = item_ready;
  assign out_valid_o  = out_v_q;
  assign stats_o      = stats_q;

endmodule
`default_nettype wire

### verif/adc_batch_stats_dip_detector_top_tb.sv
// Self-checking testbench of the ADC batch statistics and dip detector top level.
`timescale 1ns / 1ps
module adc_batch_stats_dip_detector_top_tb;
  import abdd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LONG_BATCH = 40;
  localparam int unsigned ITEMS_PER_PHASE = 40;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic [TIME_W-1:0]   ts;
    logic                last;
  } adc_in_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata = '0;   // sample[11:0], timestamp[59:12], zero
  logic                  s_axis_tlast = 1'b0; // last_of_batch
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [199:0]          m_axis_tdata;        // samples_in_batch, dips_in_batch,
                                              // min_sample, max_sample, average_q16,
                                              // min_interval, max_interval,
                                              // interval_sum, zero
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  adc_batch_stats_dip_detector_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // register copies
  logic [WEIGHT_W-1:0] w_cfg   = WEIGHT_RESET;
  logic [LEVEL_W-1:0]  thr_cfg = THRESHOLD_RESET;
  logic [LEVEL_W-1:0]  rel_cfg = RELEASE_RESET;

  // running state of the detector
  logic [AVG_W-1:0]    ema_q16   = '0;
  logic                in_dip    = 1'b0;
  logic                batch_live = 1'b0;
  logic [SAMPLE_W-1:0] lo_smp    = '0;
  logic [SAMPLE_W-1:0] hi_smp    = '0;
  logic [TIME_W-1:0]   last_ts   = '0;
  logic [GAP_W-1:0]    gap_min   = '1;
  logic [GAP_W-1:0]    gap_max   = '0;
  logic [63:0]         gap_sum   = '0;
  logic [COUNT_W-1:0]  n_smp     = '0;
  logic [COUNT_W-1:0]  n_dip     = '0;

  adc_in_t     feed_q[$];
  stats_t      stats_due[$];
  int unsigned n_fed = 0;
  int unsigned n_taken = 0;
  int unsigned n_bad = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        rx_hold = 1'b0;
  logic [TIME_W-1:0] ts_now = '0;
  int          level = 2048;

  logic [WEIGHT_W-1:0]   set_w   [6] = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'hF0E4, 16'd4000};
  logic [CFG_DATA_W-1:0] set_thr [6] = '{16'd0, 16'd4095, 16'd100, 16'd300, 16'hF0E4, 16'd20};
  logic [CFG_DATA_W-1:0] set_rel [6] = '{16'd0, 16'd4095, 16'd4095, 16'd50, 16'hA044, 16'd10};
  int unsigned idle_mode  [4] = '{0, 52, 0, 10};
  int unsigned stall_mode [4] = '{0, 0, 52, 10};

  function automatic void predict_sample(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] ts,
                                         logic last);
    logic [63:0]       xq, acc, dev, gap, avg64;
    logic [TIME_W-1:0] d48;
    stats_t            res;
    xq  = {36'd0, smp, 16'd0};
    acc = {36'd0, ema_q16} * (64'd65536 - {48'd0, w_cfg}) + xq * {48'd0, w_cfg} + 64'd32768;
    ema_q16 = acc[43:16];
    if (!batch_live) begin
      lo_smp = smp;
      hi_smp = smp;
    end else begin
      d48 = ts - last_ts;
      gap = (d48 > 48'h0000_FFFF_FFFF) ? 64'hFFFF_FFFF : {16'd0, d48};
      if (gap[31:0] < gap_min) gap_min = gap[31:0];
      if (gap[31:0] > gap_max) gap_max = gap[31:0];
      gap_sum = gap_sum + gap;
      if (gap_sum > 64'h0000_FFFF_FFFF_FFFF) gap_sum = 64'h0000_FFFF_FFFF_FFFF;
      if (smp < lo_smp) lo_smp = smp;
      if (smp > hi_smp) hi_smp = smp;
    end
    last_ts = ts;
    batch_live = 1'b1;
    if (n_smp != 16'hFFFF) n_smp++;
    avg64 = {36'd0, ema_q16};
    dev = (xq >= avg64) ? xq - avg64 : avg64 - xq;
    if (dev >= {36'd0, thr_cfg, 16'd0}) begin
      if (!in_dip) begin
        if (n_dip != 16'hFFFF) n_dip++;
        in_dip = 1'b1;
      end
    end else if (in_dip && dev < {36'd0, rel_cfg, 16'd0}) begin
      in_dip = 1'b0;
    end
    if (last) begin
      res.samples_in_batch = n_smp;
      res.dips_in_batch    = n_dip;
      res.min_sample       = lo_smp;
      res.max_sample       = hi_smp;
      res.average_q16      = ema_q16;
      res.min_interval     = gap_min;
      res.max_interval     = gap_max;
      res.interval_sum     = gap_sum[47:0];
      stats_due.push_back(res);
      batch_live = 1'b0;
      lo_smp  = '0;
      hi_smp  = '0;
      gap_min = '1;
      gap_max = '0;
      gap_sum = '0;
      n_smp   = '0;
      n_dip   = '0;
    end
  endfunction

  function automatic void cmp(string name, longint unsigned want_v, longint unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      n_bad++;
    end
  endfunction

  always @(posedge clk_i) begin : drive
    adc_in_t nx;
    if (s_axis_tvalid && s_axis_tready) begin
      predict_sample(s_axis_tdata[11:0], s_axis_tdata[59:12], s_axis_tlast);
      n_taken++;
    end
    if (s_axis_tvalid && !s_axis_tready) begin
      // hold the offered item
    end else if (feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      nx = feed_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {4'd0, nx.ts, nx.smp};
      s_axis_tlast  <= nx.last;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : watch
    stats_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[195:0];
      if (stats_due.size() == 0) begin
        $error("stats item with no closed batch waiting");
        n_bad++;
      end else begin
        want = stats_due.pop_front();
        cmp("samples_in_batch", want.samples_in_batch, got.samples_in_batch);
        cmp("dips_in_batch", want.dips_in_batch, got.dips_in_batch);
        cmp("min_sample", want.min_sample, got.min_sample);
        cmp("max_sample", want.max_sample, got.max_sample);
        cmp("average_q16", want.average_q16, got.average_q16);
        cmp("min_interval", want.min_interval, got.min_interval);
        cmp("max_interval", want.max_interval, got.max_interval);
        cmp("interval_sum", want.interval_sum, got.interval_sum);
      end
    end
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  task automatic push_item(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] ts, logic last);
    adc_in_t it;
    it.smp  = smp;
    it.ts   = ts;
    it.last = last;
    feed_q.push_back(it);
    n_fed++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_fed || stats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_EMA_WEIGHT:    w_cfg = val;
      CFG_DIP_THRESHOLD: thr_cfg = val[LEVEL_W-1:0];
      CFG_DIP_RELEASE:   rel_cfg = val[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_batch(int unsigned len);
    int unsigned k;
    int          v;
    if ($urandom_range(3) == 0) level = int'($urandom_range(4095));
    for (k = 0; k < len; k++) begin
      case ($urandom_range(15))
        0: ts_now = {16'($urandom_range(65535)), $urandom()};
        1: ts_now = ts_now + {16'($urandom_range(65535)), $urandom()};
        2: ;
        default: ts_now = ts_now + 48'($urandom_range(5000, 1));
      endcase
      case ($urandom_range(7))
        0: v = $urandom_range(4095);
        1: v = $urandom_range(1) ? 4095 : 0;
        2: v = level - int'($urandom_range(600, 150));
        3: v = level + int'($urandom_range(600, 150));
        default: v = level + int'($urandom_range(40)) - 20;
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      push_item(v[SAMPLE_W-1:0], ts_now, k == len - 1);
    end
  endtask

  task automatic run_phase(int unsigned n_items, int unsigned idle, int unsigned stall);
    int unsigned done;
    int unsigned len;
    idle_pct  = idle;
    stall_pct = stall;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(40, 13);
      end else begin
        len = $urandom_range(12, 1);
      end
      queue_batch(len);
      done += len;
    end
    wait_drained();
  endtask

  initial begin
    int unsigned s, m, k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_item(12'd0, 48'h0, 1'b1);
    push_item(12'd4095, 48'hFFFF_FFFF_FFFF, 1'b0);
    push_item(12'd4095, 48'h0000_0000_0004, 1'b0);
    push_item(12'd0, 48'h0000_0000_0004, 1'b0);
    push_item(12'd4095, 48'h0001_0000_0004, 1'b0);
    push_item(12'd2048, 48'h0001_0000_0005, 1'b1);
    push_item(12'd4095, 48'h8000_0000_0000, 1'b1);
    push_item(12'd1234, 48'h8000_0000_0064, 1'b0);
    push_item(12'h555, 48'h5555_5555_5555, 1'b0);
    push_item(12'hAAA, 48'hAAAA_AAAA_AAAA, 1'b0);
    push_item(12'd4094, 48'hAAAA_AAAA_AAAB, 1'b0);
    push_item(12'd1, 48'hAAAA_AAAA_AAAB, 1'b0);
    push_item(12'd0, 48'hAAAA_AAAB_0000, 1'b1);
    wait_drained();

    for (s = 0; s < 6; s++) begin
      write_reg(CFG_EMA_WEIGHT, set_w[s]);
      write_reg(CFG_DIP_THRESHOLD, set_thr[s]);
      write_reg(CFG_DIP_RELEASE, set_rel[s]);
      if (s == 5) write_reg(CFG_NONE, 16'hFFFF);
      for (m = 0; m < 4; m++) run_phase(ITEMS_PER_PHASE, idle_mode[m], stall_mode[m]);
    end

    // stall the output while items keep coming
    idle_pct  = 0;
    stall_pct = 10;
    for (k = 0; k < 40; k++) queue_batch($urandom_range(3, 1));
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    wait_drained();

    // a short batch at full weight, then one long batch with every interval clipped
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(CFG_EMA_WEIGHT, 16'hFFFF);
    for (k = 0; k < 4; k++) push_item(12'd2048, ts_now + 48'(k), k == 3);
    wait_drained();
    write_reg(CFG_EMA_WEIGHT, 16'd1);
    write_reg(CFG_DIP_THRESHOLD, 16'd1000);
    write_reg(CFG_DIP_RELEASE, 16'd100);
    for (k = 0; k < LONG_BATCH; k++) begin
      ts_now = ts_now + 48'h0100_0000_0000;
      case (k % 4)
        0: push_item(12'd4095, ts_now, 1'b0);
        2: push_item(12'd1, ts_now, 1'b0);
        default: push_item(12'd2048, ts_now, k == LONG_BATCH - 1);
      endcase
    end
    wait_drained();

    if (n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
